### rtl/split_stream_lz_decoder_assert.svh
// Assertion macros used by the decoder checker.
`ifndef SPLIT_STREAM_LZ_DECODER_ASSERT_SVH
`define SPLIT_STREAM_LZ_DECODER_ASSERT_SVH

// same-cycle implication, masked during reset
`define LZD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzd assertion failed");

// next-cycle implication, masked during reset
`define LZD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzd assertion failed");

// next-cycle implication, also checked in reset
`define LZD_ASSERT_NXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lzd assertion failed");

`endif

### rtl/lzd_pkg.sv
// Shared types and constants for the split-stream LZ decoder.
package lzd_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int COUNT_W = 24;
  localparam int DIST_W  = 13;
  localparam int LEN_W   = 3;
  localparam int REM_W   = 4;

  localparam int LEN_SHIFT = 'h0D;
  localparam logic [DIST_W-1:0] DIST_MASK = 13'h1FFF;
  localparam logic [REM_W-1:0]  MATCH_MIN = 4'd3;
  localparam logic [COUNT_W-1:0] SIZE_RESET = 24'hFFFFFF;

  typedef enum logic {
    REQ_MATCH   = 1'b0,
    REQ_LITERAL = 1'b1
  } req_t;

  // where the byte in the read stage comes from
  typedef enum logic [1:0] {
    SRC_RAM    = 2'd0,
    SRC_FWD    = 2'd1,
    SRC_DIRECT = 2'd2
  } src_t;

  typedef struct packed {
    logic last;
    logic eoo;
    logic bad;
  } flags_t;

endpackage

### rtl/lzd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/split_stream_lz_decoder.sv
// Split-stream LZ decoder top level: copy engine, history RAM and output register.
//
// Input channel (in_valid/in_stall): one beat is a literal byte or a 16-bit
// match word (length = bits 15..13 + 3, distance = bits 12..0 + 1).
// Output channel (out_valid/out_stall): one decoded byte per beat, with
// last_of_run on the final byte of an item, end_of_output when the count
// reaches cfg output_size, and bad_distance (byte forced to zero) when the
// distance reaches before the first byte.
// cfg_we/cfg_wdata write output_size; write it only while the block is idle.
// The first byte of an item passes the item register, the read stage and the
// output register. Throughput: one byte per cycle while the output is not
// stalled; a literal gives one byte and a match 3 to 10 bytes, and an item
// that produces nothing issues none. The next item is accepted in the cycle
// its predecessor issues its last byte or stops at output_size. The rate is
// set by the single history write, and at most one history read, per byte.
// Reset (synchronous, active low) empties the pipeline, zeroes the byte
// count and write pointer and sets output_size to all ones; history content
// is not cleared. A stalled output holds its beat and the pipeline waits.
module split_stream_lz_decoder #(
  parameter int HISTORY_DEPTH = 8192
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lzd_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [lzd_pkg::WORD_W-1:0]  in_match_word,
  input  logic [lzd_pkg::BYTE_W-1:0]  in_literal_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lzd_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last_of_run,
  output logic                        out_end_of_output,
  output logic                        out_bad_distance
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

  localparam int CW = lzd_pkg::COUNT_W;
  localparam int BW = lzd_pkg::BYTE_W;
  localparam int DW = lzd_pkg::DIST_W;
  localparam int RW = lzd_pkg::REM_W;

  logic [CW-1:0] size_r, size_nxt;

  logic               active_r, active_nxt;
  lzd_pkg::req_t      kind_r, kind_nxt;
  logic [DW-1:0]      dist_r, dist_nxt;
  logic [BW-1:0]      lit_r, lit_nxt;
  logic [RW-1:0]      rem_r, rem_nxt;

  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] prod_r, prod_nxt;

  logic              b_valid_r, b_valid_nxt;
  lzd_pkg::src_t     b_src_r, b_src_nxt;
  logic [BW-1:0]     b_byte_r, b_byte_nxt;
  lzd_pkg::flags_t   b_flags_r, b_flags_nxt;
  logic [BW-1:0]     last_r, last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BW-1:0]     out_byte_r, out_byte_nxt;
  lzd_pkg::flags_t   out_flags_r, out_flags_nxt;

  logic          out_free, b_emit, a_slot, a_stop, a_issue, a_end, a_last, a_fin;
  logic          in_acc, a_bad, rd_en;
  logic [CW-1:0] prod_eff, prod_inc;
  logic [AW-1:0] wp_eff, rd_addr;
  logic [AW:0]   dist_ext, addr_diff;
  logic [BW-1:0] b_value, ram_rdata;
  lzd_pkg::src_t a_src;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    b_emit   = b_valid_r && out_free;
    a_slot   = active_r && (!b_valid_r || b_emit);
    prod_eff = prod_r + CW'(b_valid_r);
    prod_inc = prod_eff + CW'(1);
    a_stop   = prod_eff >= size_r;
    a_issue  = a_slot && !a_stop;
    a_end    = prod_inc == size_r;
    a_last   = (rem_r == RW'(1)) || a_end;
    a_fin    = a_slot && (a_stop || a_last);
    in_stall = active_r && !a_fin;
    in_acc   = in_valid && !in_stall;

    if (b_valid_r && (wp_r == WP_LAST)) begin
      wp_eff = '0;
    end else begin
      wp_eff = wp_r + AW'(b_valid_r);
    end
    dist_ext  = (AW+1)'(dist_r) + (AW+1)'(1);
    addr_diff = {1'b0, wp_eff} - dist_ext;
    if (addr_diff[AW]) begin
      rd_addr = AW'(addr_diff + DEPTH_X);
    end else begin
      rd_addr = addr_diff[AW-1:0];
    end

    a_bad = (kind_r == lzd_pkg::REQ_MATCH) && (CW'(dist_r) >= prod_eff);
    if (kind_r == lzd_pkg::REQ_LITERAL || a_bad) begin
      a_src = lzd_pkg::SRC_DIRECT;
    end else if (b_valid_r && dist_r == '0) begin
      a_src = lzd_pkg::SRC_FWD;
    end else begin
      a_src = lzd_pkg::SRC_RAM;
    end
    rd_en = a_issue && (a_src == lzd_pkg::SRC_RAM);

    case (b_src_r)
      lzd_pkg::SRC_RAM:    b_value = ram_rdata;
      lzd_pkg::SRC_FWD:    b_value = last_r;
      lzd_pkg::SRC_DIRECT: b_value = b_byte_r;
      default:             b_value = b_byte_r;
    endcase
  end

  always_comb begin
    size_nxt = cfg_we ? cfg_wdata : size_r;

    active_nxt = active_r;
    kind_nxt   = kind_r;
    dist_nxt   = dist_r;
    lit_nxt    = lit_r;
    rem_nxt    = rem_r;
    if (in_acc) begin
      active_nxt = 1'b1;
      kind_nxt   = lzd_pkg::req_t'(in_req_type);
      dist_nxt   = in_match_word[DW-1:0] & lzd_pkg::DIST_MASK;
      lit_nxt    = in_literal_byte;
      if (lzd_pkg::req_t'(in_req_type) == lzd_pkg::REQ_LITERAL) begin
        rem_nxt = RW'(1);
      end else begin
        rem_nxt = RW'(in_match_word[lzd_pkg::LEN_SHIFT +: lzd_pkg::LEN_W])
                  + lzd_pkg::MATCH_MIN;
      end
    end else if (a_fin) begin
      active_nxt = 1'b0;
    end else if (a_issue) begin
      rem_nxt = rem_r - RW'(1);
    end

    b_valid_nxt = b_valid_r;
    b_src_nxt   = b_src_r;
    b_byte_nxt  = b_byte_r;
    b_flags_nxt = b_flags_r;
    if (a_issue) begin
      b_valid_nxt = 1'b1;
      b_src_nxt   = a_src;
      b_byte_nxt  = a_bad ? '0 : lit_r;
      b_flags_nxt = '{last: a_last, eoo: a_end, bad: a_bad};
    end else if (b_emit) begin
      b_valid_nxt = 1'b0;
    end

    wp_nxt        = wp_r;
    prod_nxt      = prod_r;
    last_nxt      = last_r;
    out_byte_nxt  = out_byte_r;
    out_flags_nxt = out_flags_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (b_emit) begin
      wp_nxt        = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
      prod_nxt      = prod_r + CW'(1);
      last_nxt      = b_value;
      out_byte_nxt  = b_value;
      out_flags_nxt = b_flags_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= lzd_pkg::SIZE_RESET;
      active_r    <= 1'b0;
      wp_r        <= '0;
      prod_r      <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      active_r    <= active_nxt;
      wp_r        <= wp_nxt;
      prod_r      <= prod_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    dist_r      <= dist_nxt;
    lit_r       <= lit_nxt;
    rem_r       <= rem_nxt;
    b_src_r     <= b_src_nxt;
    b_byte_r    <= b_byte_nxt;
    b_flags_r   <= b_flags_nxt;
    last_r      <= last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_flags_r <= out_flags_nxt;
  end

  lzd_ram #(
    .WIDTH (BW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (b_emit),
    .waddr (wp_r),
    .wdata (b_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_run   = out_flags_r.last;
  assign out_end_of_output = out_flags_r.eoo;
  assign out_bad_distance  = out_flags_r.bad;

endmodule

### rtl/lzd_checker.sv
// Port-level checker for the split-stream LZ decoder, bound to the top level.
`include "split_stream_lz_decoder_assert.svh"

module lzd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [lzd_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_last_of_run,
  input logic                       out_end_of_output,
  input logic                       out_bad_distance
);

  `LZD_ASSERT_IMP(a_bad_is_zero, out_valid && out_bad_distance, out_byte == '0)
  `LZD_ASSERT_IMP(a_end_is_last, out_valid && out_end_of_output, out_last_of_run)
  `LZD_ASSERT_NXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_byte))
  `LZD_ASSERT_NXT_ALL(a_reset_empty, !rst_n, !out_valid)

endmodule

bind split_stream_lz_decoder lzd_checker u_lzd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_byte          (out_byte),
  .out_last_of_run   (out_last_of_run),
  .out_end_of_output (out_end_of_output),
  .out_bad_distance  (out_bad_distance)
);
